>>> src/edr_pkg.sv
`default_nettype none
package edr_pkg;

   localparam int Steps = 16;
   localparam logic signed [35:0] CordicGain = 36'sd652032874;

   // arctangent per step, 2^32 units per turn
   function automatic logic signed [35:0] atan_turn(input logic [3:0] idx);
      logic signed [35:0] v;
      case (idx)
         4'd0: v = 36'sh020000000;
         4'd1: v = 36'sh012E4051E;
         4'd2: v = 36'sh009FB385B;
         4'd3: v = 36'sh0051111D4;
         4'd4: v = 36'sh0028B0D43;
         4'd5: v = 36'sh00145D7E1;
         4'd6: v = 36'sh000A2F61E;
         4'd7: v = 36'sh000517C55;
         4'd8: v = 36'sh00028BE53;
         4'd9: v = 36'sh000145F2F;
         4'd10: v = 36'sh0000A2F98;
         4'd11: v = 36'sh0000517CC;
         4'd12: v = 36'sh000028BE6;
         4'd13: v = 36'sh0000145F3;
         4'd14: v = 36'sh00000A2FA;
         default: v = 36'sh00000517D;
      endcase
      return v;
   endfunction

   // one cordic lane: x, y and residual angle
   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
      logic               flip;
   } lane_type;

   // contents of one cell of the pipeline
   typedef struct packed {
      logic               valid;
      lane_type [2:0]     lane;
      logic signed [32:0] n0;
      logic signed [32:0] n1;
      logic signed [32:0] n2;
   } cell_type;

endpackage
`default_nettype wire

>>> src/edr_cordic_cell.sv
`default_nettype none
module edr_cordic_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic [3:0]          step,
   input  wire edr_pkg::cell_type   cell_in,
   output edr_pkg::cell_type        cell_out
);

   edr_pkg::cell_type cell_in_w, cell_ff;

   // one micro-rotation on each of the three angle lanes
   always_comb begin
      cell_in_w = cell_in;
      for (int k = 0; k < 3; k++) begin
         if (!cell_in.lane[k].z[35]) begin
            cell_in_w.lane[k].x = cell_in.lane[k].x - (cell_in.lane[k].y >>> step);
            cell_in_w.lane[k].y = cell_in.lane[k].y + (cell_in.lane[k].x >>> step);
            cell_in_w.lane[k].z = cell_in.lane[k].z - edr_pkg::atan_turn(step);
         end else begin
            cell_in_w.lane[k].x = cell_in.lane[k].x + (cell_in.lane[k].y >>> step);
            cell_in_w.lane[k].y = cell_in.lane[k].y - (cell_in.lane[k].x >>> step);
            cell_in_w.lane[k].z = cell_in.lane[k].z + edr_pkg::atan_turn(step);
         end
      end
   end

   // advance only when downstream moves
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

>>> src/edr_rotate.sv
`default_nettype none
module edr_rotate (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire edr_pkg::cell_type   cell_in,
   output logic                     out_valid,
   output logic signed [31:0]       out_x,
   output logic signed [31:0]       out_y,
   output logic signed [31:0]       out_z,
   output logic                     out_sat
);

   typedef logic signed [15:0] q15_type;

   // q2.30 to q1.15 with rounding and clip
   function automatic q15_type to_q15(input logic signed [35:0] v, input logic flip);
      logic signed [35:0] f;
      logic signed [36:0] r;
      f = flip ? -v : v;
      r = ($signed({f[35], f}) + 37'sd16384) >>> 15;
      if (r > 37'sd32767) return 16'sh7fff;
      if (r < -37'sd32768) return 16'sh8000;
      return r[15:0];
   endfunction

   // q3.45 sum to q2.30
   function automatic logic signed [32:0] to_q30(input logic signed [47:0] v);
      logic signed [47:0] r;
      r = (v + 48'sd16384) >>> 15;
      return r[32:0];
   endfunction

   // stage a: sines and cosines
   logic               va_ff, vb_ff, vc_ff, vd_ff;
   q15_type            sr_ff, cr_ff, sp_ff, cp_ff, sy_ff, cy_ff;
   logic signed [32:0] na_ff [3], nb_ff [3], nc_ff [3];
   // stage b: pair products and sr*sp, cr*sp
   logic signed [31:0] cpcy_ff, cpsy_ff, crsy_ff, crcy_ff, srcp_ff, srsy_ff, srcy_ff,
                       crcp_ff, srsp_ff, crsp_ff;
   q15_type            spb_ff, sycb_ff, cycb_ff;
   // stage c: matrix entries q2.30
   logic signed [32:0] m_ff [9];
   // stage d: rounded terms
   logic signed [33:0] t_ff [9];
   logic signed [63:0] pm [9];
   logic signed [35:0] sum [3];
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic               ov_ff, os_ff;
   logic               sat_w;
   logic signed [31:0] o_w [3];

   always_comb begin
      sat_w = 1'b0;
      for (int r = 0; r < 3; r++) begin
         sum[r] = 36'(t_ff[3*r]) + 36'(t_ff[3*r+1]) + 36'(t_ff[3*r+2]);
         if (sum[r] > 36'sh07fffffff) begin
            o_w[r] = 32'sh7fffffff; sat_w = 1'b1;
         end else if (sum[r] < -36'sh080000000) begin
            o_w[r] = 32'sh80000000; sat_w = 1'b1;
         end else begin
            o_w[r] = sum[r][31:0];
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            pm[3*r+k] = 64'(m_ff[3*r+k]) * 64'(nc_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0; vb_ff <= 1'b0; vc_ff <= 1'b0; vd_ff <= 1'b0; ov_ff <= 1'b0;
      end else if (enable) begin
         va_ff <= cell_in.valid; vb_ff <= va_ff; vc_ff <= vb_ff;
         vd_ff <= vc_ff; ov_ff <= vd_ff;
      end
      if (enable) begin
         // stage a
         sr_ff <= to_q15(cell_in.lane[0].y, cell_in.lane[0].flip);
         cr_ff <= to_q15(cell_in.lane[0].x, cell_in.lane[0].flip);
         sp_ff <= to_q15(cell_in.lane[1].y, cell_in.lane[1].flip);
         cp_ff <= to_q15(cell_in.lane[1].x, cell_in.lane[1].flip);
         sy_ff <= to_q15(cell_in.lane[2].y, cell_in.lane[2].flip);
         cy_ff <= to_q15(cell_in.lane[2].x, cell_in.lane[2].flip);
         na_ff[0] <= cell_in.n0; na_ff[1] <= cell_in.n1; na_ff[2] <= cell_in.n2;
         // stage b
         cpcy_ff <= cp_ff * cy_ff; cpsy_ff <= cp_ff * sy_ff;
         crsy_ff <= cr_ff * sy_ff; crcy_ff <= cr_ff * cy_ff;
         srcp_ff <= sr_ff * cp_ff; srsy_ff <= sr_ff * sy_ff;
         srcy_ff <= sr_ff * cy_ff; crcp_ff <= cr_ff * cp_ff;
         srsp_ff <= sr_ff * sp_ff; crsp_ff <= cr_ff * sp_ff;
         spb_ff <= sp_ff; sycb_ff <= sy_ff; cycb_ff <= cy_ff;
         nb_ff <= na_ff;
         // stage c
         m_ff[0] <= to_q30(48'(cpcy_ff) <<< 15);
         m_ff[1] <= to_q30(48'(cpsy_ff) <<< 15);
         m_ff[2] <= -(33'(spb_ff) <<< 15);
         m_ff[3] <= to_q30(-(48'(crsy_ff) <<< 15) + 48'(srsp_ff) * 48'(cycb_ff));
         m_ff[4] <= to_q30((48'(crcy_ff) <<< 15) + 48'(srsp_ff) * 48'(sycb_ff));
         m_ff[5] <= to_q30(48'(srcp_ff) <<< 15);
         m_ff[6] <= to_q30((48'(srsy_ff) <<< 15) + 48'(crsp_ff) * 48'(cycb_ff));
         m_ff[7] <= to_q30(-(48'(srcy_ff) <<< 15) + 48'(crsp_ff) * 48'(sycb_ff));
         m_ff[8] <= to_q30(48'(crcp_ff) <<< 15);
         nc_ff <= nb_ff;
         // stage d: rounded terms
         for (int i = 0; i < 9; i++) begin
            t_ff[i] <= 34'((pm[i] + 64'sd536870912) >>> 30);
         end
         ox_ff <= o_w[0]; oy_ff <= o_w[1]; oz_ff <= o_w[2]; os_ff <= sat_w;
      end
   end

   assign out_valid = ov_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;
   assign out_sat = os_ff;

endmodule
`default_nettype wire

>>> src/euler_dcm_body_frame_rotation.sv
`default_nettype none
// Euler ZYX rotation of a world-frame vector into the body frame.
// req_ channel: roll, pitch, yaw binary angles and a Q16.16 world vector,
// taken when req_valid is high and req_stall low. rsp_ channel: body vector
// in Q16.16 and a saturation flag, taken when rsp_valid is high and rsp_stall
// low. One item is accepted per cycle while req_stall is low; each result
// passes through one input cell, 16 CORDIC cells and 5 matrix stages. The
// whole pipeline is one chain that advances together, so a stall on rsp_
// holds every stage and raises req_stall only while the final stage holds an
// undelivered result. Synchronous reset empties the pipeline; nothing else
// is kept between items.
module euler_dcm_body_frame_rotation (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_roll_angle,
   input  wire logic signed [15:0] req_pitch_angle,
   input  wire logic signed [15:0] req_yaw_angle,
   input  wire logic signed [31:0] req_world_x,
   input  wire logic signed [31:0] req_world_y,
   input  wire logic signed [31:0] req_world_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_body_x,
   output logic signed [31:0]      rsp_body_y,
   output logic signed [31:0]      rsp_body_z,
   output logic                    rsp_saturated
);

   edr_pkg::cell_type chain [edr_pkg::Steps+1];
   edr_pkg::cell_type head_ff;
   logic enable;
   logic signed [15:0] ang [3];

   assign enable = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;
   assign ang[0] = req_roll_angle;
   assign ang[1] = req_pitch_angle;
   assign ang[2] = req_yaw_angle;

   // input cell: fold angles and negate to ned
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (enable) begin
         head_ff.valid <= req_valid;
      end
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            head_ff.lane[k].x <= edr_pkg::CordicGain;
            head_ff.lane[k].y <= '0;
            if (ang[k] >= 16'sd16384) begin
               head_ff.lane[k].flip <= 1'b1;
               head_ff.lane[k].z <= 36'(ang[k] - 17'sd32768) <<< 16;
            end else if (ang[k] < -16'sd16384) begin
               head_ff.lane[k].flip <= 1'b1;
               head_ff.lane[k].z <= 36'(ang[k] + 17'sd32768) <<< 16;
            end else begin
               head_ff.lane[k].flip <= 1'b0;
               head_ff.lane[k].z <= 36'(ang[k]) <<< 16;
            end
         end
         head_ff.n0 <= -33'(req_world_y);
         head_ff.n1 <= -33'(req_world_x);
         head_ff.n2 <= -33'(req_world_z);
      end
   end

   assign chain[0] = head_ff;

   // row of cordic cells, one step each
   for (genvar i = 0; i < edr_pkg::Steps; i++) begin : g_cell
      edr_cordic_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable), .step(4'(i)),
         .cell_in(chain[i]), .cell_out(chain[i+1])
      );
   end

   edr_rotate u_rotate (
      .clock(clock), .reset(reset), .enable(enable),
      .cell_in(chain[edr_pkg::Steps]),
      .out_valid(rsp_valid), .out_x(rsp_body_x), .out_y(rsp_body_y),
      .out_z(rsp_body_z), .out_sat(rsp_saturated)
   );

endmodule
`default_nettype wire
